// File: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue unit
// Transaction payloads, command kinds, opcodes, status codes, defaults.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_REAR   = 3'd3;
	localparam logic [2:0] OP_QUERY      = 3'd4;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic        [2:0]  opcode;
		logic signed [31:0] value;
	} deq_in_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] front_value;
		logic signed [31:0] rear_value;
		logic               is_empty;
		logic        [4:0]  count;
	} deq_out_t;

	typedef enum logic [2:0] {
		KIND_PUSH_FRONT,
		KIND_PUSH_REAR,
		KIND_POP_FRONT,
		KIND_POP_REAR,
		KIND_QUERY
	} deq_kind_t;

	typedef struct packed {
		deq_kind_t          kind;
		logic signed [31:0] value;
	} deq_cmd_t;

endpackage

// File: rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram: generic RAM, one write port and two registered read ports
// Read-during-write returns the old contents.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: rtl/deq_front.sv
// ----------------------------------------------------------------------------
// deq_front: input side of the queue unit
// Accepts transactions, decodes the opcode into a command kind and holds
// commands in a two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module deq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  deq_pkg::deq_in_t  in_item,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output deq_pkg::deq_cmd_t cmd
);
	import deq_pkg::*;

	deq_cmd_t   fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	deq_cmd_t   dec_cmd;
	logic       push;
	logic       pop;

	always_comb begin
		dec_cmd.value = in_item.value;
		unique case (in_item.opcode)
			OP_PUSH_FRONT: dec_cmd.kind = KIND_PUSH_FRONT;
			OP_PUSH_REAR:  dec_cmd.kind = KIND_PUSH_REAR;
			OP_POP_FRONT:  dec_cmd.kind = KIND_POP_FRONT;
			OP_POP_REAR:   dec_cmd.kind = KIND_POP_REAR;
			OP_QUERY:      dec_cmd.kind = KIND_QUERY;
			default:       dec_cmd.kind = KIND_QUERY;	// unused codes act as query
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("command queue count out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("command queue pointers disagree with count");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2))
		else $error("command queue lost an entry");

endmodule

// File: rtl/deq_back.sv
// ----------------------------------------------------------------------------
// deq_back: execution side of the queue unit
// Updates head, tail and count, writes pushed data to the slot RAM, reads
// the front and rear slots back and registers the result transaction.
// ----------------------------------------------------------------------------
module deq_back #(
	parameter int CAPACITY   = deq_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  deq_pkg::deq_cmd_t cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output deq_pkg::deq_out_t out_item
);
	import deq_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [AW-1:0]    LAST_IDX = AW'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		S_TAKE,
		S_READ,
		S_SEND
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      tail_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         status_q;
	logic               out_valid_q;
	deq_out_t           out_q;

	logic [AW-1:0]      head_n;
	logic [AW-1:0]      tail_n;
	logic [CNT_W-1:0]   cnt_n;
	logic [1:0]         status_n;
	logic               we;
	logic [AW-1:0]      waddr;
	logic signed [63:0] val_ext;
	logic [AW-1:0]      rear_idx;
	logic [DATA_WIDTH-1:0] rdata_front;
	logic [DATA_WIDTH-1:0] rdata_rear;
	logic signed [63:0] front_ext;
	logic signed [63:0] rear_ext;
	logic [31:0]        cnt_wide;
	logic               full;
	logic               empty;
	logic               take;
	logic               load_out;
	deq_out_t           res;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	assign full      = (cnt_q == CNT_FULL);
	assign empty     = (cnt_q == '0);
	assign cmd_ready = (state_q == S_TAKE);
	assign take      = cmd_valid && cmd_ready;
	assign val_ext   = 64'(cmd.value);

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		cnt_n    = cnt_q;
		status_n = STAT_DONE;
		we       = 1'b0;
		waddr    = tail_q;
		unique case (cmd.kind)
			KIND_PUSH_FRONT: begin
				if (full) begin
					status_n = STAT_FULL;
				end else begin
					head_n = idx_dec(head_q);
					waddr  = head_n;
					we     = take;
					cnt_n  = cnt_q + CNT_W'(1);
				end
			end
			KIND_PUSH_REAR: begin
				if (full) begin
					status_n = STAT_FULL;
				end else begin
					tail_n = idx_inc(tail_q);
					we     = take;
					cnt_n  = cnt_q + CNT_W'(1);
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					status_n = STAT_EMPTY;
				end else begin
					head_n = idx_inc(head_q);
					cnt_n  = cnt_q - CNT_W'(1);
				end
			end
			KIND_POP_REAR: begin
				if (empty) begin
					status_n = STAT_EMPTY;
				end else begin
					tail_n = idx_dec(tail_q);
					cnt_n  = cnt_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// tail points one past the rear entry
	assign rear_idx = idx_dec(tail_q);

	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (val_ext[DATA_WIDTH-1:0]),
		.raddr_a (head_q),
		.raddr_b (rear_idx),
		.rdata_a (rdata_front),
		.rdata_b (rdata_rear)
	);

	assign front_ext = 64'($signed(rdata_front));
	assign rear_ext  = 64'($signed(rdata_rear));
	assign cnt_wide  = 32'(cnt_q);

	always_comb begin
		res.status   = status_q;
		res.is_empty = empty;
		res.count    = cnt_wide[4:0];
		if (empty) begin
			res.front_value = '0;
			res.rear_value  = '0;
		end else begin
			res.front_value = front_ext[31:0];
			res.rear_value  = rear_ext[31:0];
		end
	end

	assign load_out  = (state_q == S_SEND) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_TAKE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			status_q    <= STAT_DONE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_TAKE: begin
					if (take) begin
						head_q   <= head_n;
						tail_q   <= tail_n;
						cnt_q    <= cnt_n;
						status_q <= status_n;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (load_out) begin
						state_q <= S_TAKE;
					end
				end
				default: begin
					state_q <= S_TAKE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("entry count above capacity");

	a_take_read: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_READ))
		else $error("command taken without read cycle");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_TAKE) |=> (cnt_q == $past(cnt_q)))
		else $error("count changed outside command take");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_empty) |->
			(out_q.front_value == 0 && out_q.rear_value == 0 && out_q.count == 5'd0))
		else $error("empty result carries data");

	a_send_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEND && !out_valid_q) |=> (state_q == S_TAKE && out_valid_q))
		else $error("result not issued into free output register");

endmodule

// File: rtl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue in a ring buffer
// Push and pop at either end, or query, with one result per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_item): one operation per transaction,
//     opcode push front, push rear, pop front, pop rear or query; value is
//     the word pushed. Unused opcodes behave as query.
//   out channel (out_valid/out_ready/out_item): exactly one result per
//     operation, in order: status, front and rear values (0 when empty),
//     empty flag and entry count after the operation.
//   A two-entry command queue sits between the input decoder and the
//   execution stage, so input keeps being taken while a result waits.
//   The execute state machine handles one operation at a time: update
//   pointers and write slot, read front/rear slots from the
//   registered-read RAM, load the output register; the next command is
//   taken only after the result is loaded.
//   Reset: queue empty, head and tail at slot 0, no result pending. Slot
//   RAM is not cleared; only held entries ever reach the output.
//   Output stall: the result stays in the output register; the back end
//   holds, and the command queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
	parameter int CAPACITY   = deq_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  deq_pkg::deq_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output deq_pkg::deq_out_t out_item
);
	import deq_pkg::*;

	logic     cmd_valid;
	logic     cmd_ready;
	deq_cmd_t cmd;

	deq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	deq_back #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
